// File: rtl/adl_pkg.sv
// ----------------------------------------------------------------------------
// adl_pkg: shared types and constants for the ADC distance linearizer
// Word layouts, controller/datapath links, register indexes, fixed widths.
// ----------------------------------------------------------------------------
package adl_pkg;

  // field widths
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned SCNT_W      = 10;               // sample counter
  localparam int unsigned SUM_W       = SAMPLE_BITS + SCNT_W;
  localparam int unsigned FRAC_W      = 4;                // 10.4 average
  localparam int unsigned DVD_W       = SUM_W + FRAC_W;   // dividend bits
  localparam int unsigned DIV_W       = SCNT_W + 1;       // divisor up to 1024
  localparam int unsigned AVG_W       = 14;
  localparam int unsigned ENTRY_W     = 14;
  localparam int unsigned EIDX_W      = 8;
  localparam int unsigned QCM_W       = 10;
  localparam int unsigned SPR_W       = 10;
  localparam int unsigned ECNT_W      = 9;

  localparam int unsigned TABLE_DEPTH_DEF = 256;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAXR   = 2'd3;

  localparam logic [SPR_W-1:0]  SPR_RST    = 10'd100;
  localparam logic [ECNT_W-1:0] ECNT_RST   = 9'd142;
  localparam logic [QCM_W-1:0]  OFFSET_RST = 10'd40;
  localparam logic [QCM_W-1:0]  MAXR_RST   = 10'd200;

  // entry i sits at 40 + 2i quarter-cm; midpoint to entry i-1 is 39 + 2i
  localparam int unsigned DIST_FIRST = 40;
  localparam int unsigned DIST_BASE  = 39;

  typedef struct packed {
    logic               req_type;      // 0 = sample, 1 = table write
    logic [SAMPLE_BITS-1:0] sample;
    logic [EIDX_W-1:0]  entry_index;
    logic [ENTRY_W-1:0] entry_value;
  } adl_in_t;

  typedef struct packed {
    logic [QCM_W-1:0] distance_qcm;
    logic             valid_res;
    logic [AVG_W-1:0] average;
  } adl_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_CMP,
    S_OUT
  } adl_state_t;

  typedef struct packed {
    logic acc;          // add sample, reading not finished
    logic tbl_wr;       // table entry write
    logic div_start;    // final sample: load divider, clear accumulator
    logic div_step;
    logic search_init;
    logic rd;           // issue table read
    logic hit;          // record match
    logic next;         // advance entry
    logic load_out;
  } adl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic last_sample;
    logic div_last;
    logic search_end;
    logic hit;
    logic out_full;
  } adl_status_t;

endpackage

// File: rtl/adl_ctrl.sv
// ----------------------------------------------------------------------------
// adl_ctrl: sequencing controller
// Accepts words, runs the divide, walks the table, hands the result over.
// ----------------------------------------------------------------------------
module adl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  adl_pkg::adl_status_t status,
  output adl_pkg::adl_cmd_t   cmd
);
  import adl_pkg::*;

  adl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.is_write) begin
            cmd.tbl_wr = 1'b1;
          end else if (status.last_sample) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            cmd.acc = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.search_init = 1'b1;
          state_next      = S_RD;
        end
      end
      S_RD: begin
        if (status.search_end) begin
          state_next = S_OUT;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (status.hit) begin
          cmd.hit    = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.next   = 1'b1;
          state_next = S_RD;
        end
      end
      S_OUT: begin
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/adl_dp.sv
// ----------------------------------------------------------------------------
// adl_dp: datapath
// Settings, accumulator, bit-serial divider, threshold table, output word.
// ----------------------------------------------------------------------------
module adl_dp #(
  parameter int unsigned TABLE_DEPTH = adl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [adl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  adl_pkg::adl_in_t                  in_word,
  input  logic                              out_ready,
  output logic                              out_valid,
  output adl_pkg::adl_out_t                 out_word,
  input  adl_pkg::adl_cmd_t                 cmd,
  output adl_pkg::adl_status_t              status
);
  import adl_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DIST_W  = $clog2(2 * TABLE_DEPTH + DIST_FIRST);
  localparam int unsigned DSTEP_W = $clog2(DVD_W + 1);

  // settings
  logic [SPR_W-1:0]  spr;
  logic [ECNT_W-1:0] ecnt;
  logic [QCM_W-1:0]  offset;
  logic [QCM_W-1:0]  maxr;

  always_ff @(posedge clk) begin
    if (rst) begin
      spr    <= SPR_RST;
      ecnt   <= ECNT_RST;
      offset <= OFFSET_RST;
      maxr   <= MAXR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPR:    spr    <= SPR_W'(cfg_data);
        REG_ECNT:   ecnt   <= ECNT_W'(cfg_data);
        REG_OFFSET: offset <= QCM_W'(cfg_data);
        REG_MAXR:   maxr   <= QCM_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // accumulator
  logic [SUM_W-1:0]  sum, sum_inc;
  logic [SCNT_W-1:0] cnt, cnt_inc, need;

  assign sum_inc = sum + SUM_W'(in_word.sample);
  assign cnt_inc = cnt + SCNT_W'(1);
  assign need    = (spr == '0) ? SCNT_W'(1) : SCNT_W'(spr);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      cnt <= '0;
    end else if (cmd.div_start) begin
      sum <= '0;
      cnt <= '0;
    end else if (cmd.acc) begin
      sum <= sum_inc;
      cnt <= cnt_inc;
    end
  end

  // restoring divider, one quotient bit a cycle; dq ends holding the quotient
  logic [DVD_W-1:0]   dq;
  logic [DIV_W-1:0]   divisor, rem;
  logic [DIV_W:0]     trial;
  logic               ge;
  logic [DSTEP_W-1:0] dstep;

  assign trial = {rem, dq[DVD_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq      <= {sum_inc, {FRAC_W{1'b0}}};
      divisor <= (cnt_inc == '0) ? {1'b1, {SCNT_W{1'b0}}} : DIV_W'(cnt_inc);
      rem     <= '0;
      dstep   <= DSTEP_W'(DVD_W);
    end else if (cmd.div_step) begin
      dq    <= {dq[DVD_W-2:0], ge};
      rem   <= ge ? DIV_W'(trial - {1'b0, divisor}) : DIV_W'(trial);
      dstep <= dstep - DSTEP_W'(1);
    end
  end

  logic [AVG_W-1:0] avg;
  assign avg = dq[AVG_W-1:0];

  // threshold table
  logic [ENTRY_W-1:0] tbl [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [CNT_W-1:0]   idx, limit;

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && (32'(in_word.entry_index) < TABLE_DEPTH)) begin
      tbl[IDX_W'(in_word.entry_index)] <= in_word.entry_value;
    end
    if (cmd.rd) begin
      rd_data <= tbl[idx[IDX_W-1:0]];
    end
  end

  assign limit = (32'(ecnt) < TABLE_DEPTH) ? CNT_W'(ecnt) : CNT_W'(TABLE_DEPTH);

  // search
  logic              found;
  logic [DIST_W-1:0] hit_dist;

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (cmd.next) begin
      idx <= idx + CNT_W'(1);
    end else if (cmd.hit) begin
      found    <= 1'b1;
      hit_dist <= (idx == '0) ? DIST_W'(DIST_FIRST)
                              : DIST_W'({idx, 1'b0}) + DIST_W'(DIST_BASE);
    end
  end

  // range check and offset removal
  logic        in_range;
  logic [31:0] dist_rel;

  assign in_range = found && (32'(hit_dist) >= 32'(offset)) && (32'(hit_dist) <= 32'(maxr));
  assign dist_rel = 32'(hit_dist) - 32'(offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word.distance_qcm <= in_range ? QCM_W'(dist_rel) : '0;
      out_word.valid_res    <= in_range;
      out_word.average      <= avg;
    end
  end

  always_comb begin
    status             = '0;
    status.is_write    = in_word.req_type;
    status.last_sample = (cnt_inc == '0) || (cnt_inc >= need);
    status.div_last    = (dstep == DSTEP_W'(1));
    status.search_end  = (idx >= limit);
    status.hit         = (avg > rd_data);
    status.out_full    = out_valid && !out_ready;
  end

endmodule

// File: rtl/averaged_adc_distance_linearizer.sv
// ----------------------------------------------------------------------------
// averaged_adc_distance_linearizer: averaged ADC to distance lookup
// Averages ADC samples, divides by count, searches a calibration table.
// ----------------------------------------------------------------------------
// A table write or a non-final sample is taken without leaving idle. A final
// sample's result word follows the divide and then a read and compare of each
// entry in turn, until a match or the entry limit, when the word is loaded.
// One word per cycle is taken outside a reading; no input from a final
// sample until its result is loaded, longer while the last result is unread.
// Reset (sync): settings to defaults, sum and out_valid cleared; table kept.
module averaged_adc_distance_linearizer #(
  parameter int unsigned TABLE_DEPTH = adl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [adl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adl_pkg::CFG_DATA_W-1:0] cfg_data,
  // input words: samples and table writes
  input  logic                           in_valid,
  output logic                           in_ready,
  input  adl_pkg::adl_in_t               in_word,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output adl_pkg::adl_out_t              out_word
);
  import adl_pkg::*;

  adl_cmd_t    cmd;
  adl_status_t status;

  // controller: accept, divide, walk, deliver
  adl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: settings, sum, divider, table, output register
  adl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: rtl/adl_checker.sv
// ----------------------------------------------------------------------------
// adl_checker: port-level checks
// Watches the top-level ports of the linearizer over time.
// ----------------------------------------------------------------------------
module adl_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input adl_pkg::adl_in_t  in_word,
  input logic              out_valid,
  input logic              out_ready,
  input adl_pkg::adl_out_t out_word
);
  import adl_pkg::*;

  // a result word waits unchanged until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word dropped or changed while stalled");

  // an out-of-range or unmatched reading carries zero distance
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.valid_res |-> out_word.distance_qcm == '0)
    else $error("invalid result with non-zero distance");

  // a table write never makes the block busy
  a_write_no_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_word.req_type |=> in_ready)
    else $error("busy after table write");

  // a new result only appears after a busy spell
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a reading in progress");

endmodule

bind averaged_adc_distance_linearizer adl_checker u_adl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
